[rtl/core/slseq_pkg.sv]
// Shared types and constants for the solenoid lock sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package slseq_pkg;

    // Command codes carried by an input word.
    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_POLL = 2'd1,
        CMD_SET  = 2'd2,
        CMD_NOP  = 2'd3
    } cmd_t;

    // Sequence phase codes, as reported on the phase output.
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_BOOST_ON  = 3'd1;
    localparam logic [2:0] PH_WAIT      = 3'd2;
    localparam logic [2:0] PH_BOOST_OFF = 3'd3;
    localparam logic [2:0] PH_TURN_OFF  = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] REG_BOOST_READY    = 3'd0;
    localparam logic [2:0] REG_COIL_MIN       = 3'd1;
    localparam logic [2:0] REG_WAIT_TIMEOUT   = 3'd2;
    localparam logic [2:0] REG_BOOST_SETTLE   = 3'd3;
    localparam logic [2:0] REG_SHUTDOWN_DELAY = 3'd4;
    localparam logic [2:0] REG_BLINK_PERIOD   = 3'd5;

    // Configuration reset values.
    localparam logic [15:0] RST_BOOST_READY    = 16'd12000;
    localparam logic [15:0] RST_COIL_MIN       = 16'd13000;
    localparam logic [15:0] RST_WAIT_TIMEOUT   = 16'd15000;
    localparam logic [15:0] RST_BOOST_SETTLE   = 16'd150;
    localparam logic [15:0] RST_SHUTDOWN_DELAY = 16'd200;
    localparam logic [15:0] RST_BLINK_PERIOD   = 16'd50;

    typedef struct packed {
        logic [15:0] boost_ready_mv;
        logic [15:0] coil_min_mv;
        logic [15:0] wait_timeout_ticks;
        logic [15:0] boost_settle_ticks;
        logic [15:0] shutdown_delay_ticks;
        logic [15:0] blink_period_ticks;
    } cfg_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        request_value;
        logic        open_allowed;
        logic        button_pressed;
        logic [15:0] supply_mv;
    } item_t;

    typedef struct packed {
        logic       boost_enable;
        logic       coil_enable;
        logic       led_on;
        logic       busy_res;
        logic [2:0] phase;
    } result_t;

endpackage

`default_nettype wire

[rtl/core/solenoid_lock_sequencer_core.sv]
// Top level of the solenoid lock sequencer: input register, result register, handshakes.
// Depends on slseq_pkg, slseq_cfg and slseq_engine.
`default_nettype none

// The sequencer takes one input word per clock cycle while the result register
// drains (out_ready low on a held result stalls it) and returns exactly one
// result word for each. A word is held in an input register, the sequencer
// state is updated from it by a single pass of compare and select logic, and
// the result lands in an output register, so out_valid rises once the word has
// passed the input register and the result register. The throughput is one
// word per cycle while results drain, and is set by the state update; a
// result that waits on out_ready still leaves room for one more word in the
// input register. Configuration words are always taken (cfg_ready is high)
// and should be written only while no input word is in flight; indexes 6 and
// 7 are accepted and ignored. TIMER_BITS sets the width of the two tick
// counters, which stop at their maximum instead of wrapping.
module solenoid_lock_sequencer_core #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic        request_value,
    input  wire logic        open_allowed,
    input  wire logic        button_pressed,
    input  wire logic [15:0] supply_mv,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             boost_enable,
    output logic             coil_enable,
    output logic             led_on,
    output logic             busy_res,
    output logic [2:0]       phase,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic                s1_valid_reg, s1_valid_next;
    slseq_pkg::item_t    s1_item_reg;
    logic                out_valid_reg, out_valid_next;
    slseq_pkg::result_t  out_word_reg;
    slseq_pkg::cfg_t     cfg;
    slseq_pkg::result_t  step_result;
    logic                out_free;
    logic                step_en;
    logic                in_fire;

    assign cfg_ready = 1'b1;

    slseq_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The result register can take a new word when empty or being drained.
    // The held input word is processed exactly when its result can be stored.
    assign out_free = !out_valid_reg || out_ready;
    assign step_en  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || step_en;
    assign in_fire  = in_valid && in_ready;

    slseq_engine #(
        .TIMER_BITS (TIMER_BITS)
    ) u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (s1_item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
            s1_valid_next = 1'b1;
        else if (step_en)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (step_en)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers load only on their handshake and need no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.cmd            <= slseq_pkg::cmd_t'(cmd);
            s1_item_reg.request_value  <= request_value;
            s1_item_reg.open_allowed   <= open_allowed;
            s1_item_reg.button_pressed <= button_pressed;
            s1_item_reg.supply_mv      <= supply_mv;
        end
        if (step_en)
            out_word_reg <= step_result;
    end

    assign out_valid    = out_valid_reg;
    assign boost_enable = out_word_reg.boost_enable;
    assign coil_enable  = out_word_reg.coil_enable;
    assign led_on       = out_word_reg.led_on;
    assign busy_res     = out_word_reg.busy_res;
    assign phase        = out_word_reg.phase;

endmodule

`default_nettype wire

[rtl/core/slseq_cfg.sv]
// Configuration register file of the solenoid lock sequencer.
// Depends on slseq_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module slseq_cfg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [2:0]       wr_index,
    input  wire logic [15:0]      wr_data,
    output slseq_pkg::cfg_t       cfg
);

    slseq_pkg::cfg_t cfg_reg;
    slseq_pkg::cfg_t cfg_next;

    // Indexes beyond the last register are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                slseq_pkg::REG_BOOST_READY:    cfg_next.boost_ready_mv       = wr_data;
                slseq_pkg::REG_COIL_MIN:       cfg_next.coil_min_mv          = wr_data;
                slseq_pkg::REG_WAIT_TIMEOUT:   cfg_next.wait_timeout_ticks   = wr_data;
                slseq_pkg::REG_BOOST_SETTLE:   cfg_next.boost_settle_ticks   = wr_data;
                slseq_pkg::REG_SHUTDOWN_DELAY: cfg_next.shutdown_delay_ticks = wr_data;
                slseq_pkg::REG_BLINK_PERIOD:   cfg_next.blink_period_ticks   = wr_data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.boost_ready_mv       <= slseq_pkg::RST_BOOST_READY;
            cfg_reg.coil_min_mv          <= slseq_pkg::RST_COIL_MIN;
            cfg_reg.wait_timeout_ticks   <= slseq_pkg::RST_WAIT_TIMEOUT;
            cfg_reg.boost_settle_ticks   <= slseq_pkg::RST_BOOST_SETTLE;
            cfg_reg.shutdown_delay_ticks <= slseq_pkg::RST_SHUTDOWN_DELAY;
            cfg_reg.blink_period_ticks   <= slseq_pkg::RST_BLINK_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/core/slseq_engine.sv]
// Sequencer state and its single-pass update for one input word.
// Depends on slseq_pkg for command and phase codes and the shared structs.
`default_nettype none

module slseq_engine #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step_en,
    input  wire slseq_pkg::item_t item,
    input  wire slseq_pkg::cfg_t  cfg,
    output slseq_pkg::result_t  result
);

    // Compares between timers and 16-bit settings run at the wider of the two.
    localparam int CmpW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    logic [2:0]            phase_reg,     phase_next;
    logic                  busy_reg,      busy_next;
    logic [TIMER_BITS-1:0] phase_tmr_reg, phase_tmr_next;
    logic [TIMER_BITS-1:0] blink_tmr_reg, blink_tmr_next;
    logic [15:0]           pend_reg,      pend_next;
    logic                  toggle_reg,    toggle_next;
    logic                  boost_reg,     boost_next;
    logic                  coil_reg,      coil_next;
    logic                  led_reg,       led_next;
    logic [2:0]            sel;

    always_comb
    begin
        phase_next     = phase_reg;
        busy_next      = busy_reg;
        phase_tmr_next = phase_tmr_reg;
        blink_tmr_next = blink_tmr_reg;
        pend_next      = pend_reg;
        toggle_next    = toggle_reg;
        boost_next     = boost_reg;
        coil_next      = coil_reg;
        led_next       = led_reg;
        sel            = slseq_pkg::PH_IDLE;

        case (item.cmd)
            slseq_pkg::CMD_TICK:
            begin
                // Both timers count up and stick at all ones.
                if (phase_tmr_reg != '1)
                    phase_tmr_next = phase_tmr_reg + TIMER_BITS'(1);
                if (blink_tmr_reg != '1)
                    blink_tmr_next = blink_tmr_reg + TIMER_BITS'(1);
            end
            slseq_pkg::CMD_POLL:
            begin
                if (toggle_reg)
                begin
                    toggle_next = 1'b0;
                    if (item.open_allowed)
                    begin
                        boost_next = 1'b1;
                        phase_next = slseq_pkg::PH_BOOST_ON;
                        busy_next  = 1'b1;
                    end
                end
                if (phase_next != slseq_pkg::PH_IDLE)
                    busy_next = 1'b1;

                // The phase only runs once its timer has passed the pending delay.
                sel = (CmpW'(phase_tmr_reg) > CmpW'(pend_reg)) ? phase_next
                                                               : slseq_pkg::PH_IDLE;

                if (busy_next && !item.button_pressed &&
                    (CmpW'(blink_tmr_reg) > CmpW'(cfg.blink_period_ticks)))
                begin
                    blink_tmr_next = '0;
                    led_next       = ~led_next;
                end

                case (sel)
                    slseq_pkg::PH_IDLE:
                    begin
                    end
                    slseq_pkg::PH_BOOST_ON:
                    begin
                        boost_next = 1'b1;
                        if (item.supply_mv > cfg.boost_ready_mv)
                        begin
                            phase_tmr_next = '0;
                            pend_next      = cfg.boost_settle_ticks;
                            phase_next     = slseq_pkg::PH_WAIT;
                        end
                    end
                    slseq_pkg::PH_WAIT:
                    begin
                        if (item.button_pressed && (item.supply_mv > cfg.coil_min_mv))
                        begin
                            coil_next      = 1'b1;
                            led_next       = 1'b1;
                            phase_tmr_next = '0;
                        end
                        else if (!item.button_pressed)
                        begin
                            coil_next = 1'b0;
                        end
                        if (CmpW'(phase_tmr_next) > CmpW'(cfg.wait_timeout_ticks))
                            phase_next = slseq_pkg::PH_BOOST_OFF;
                    end
                    slseq_pkg::PH_BOOST_OFF:
                    begin
                        coil_next      = 1'b0;
                        boost_next     = 1'b0;
                        phase_tmr_next = '0;
                        pend_next      = cfg.shutdown_delay_ticks;
                        phase_next     = slseq_pkg::PH_TURN_OFF;
                    end
                    slseq_pkg::PH_TURN_OFF:
                    begin
                        phase_tmr_next = '0;
                        phase_next     = slseq_pkg::PH_IDLE;
                        busy_next      = 1'b0;
                    end
                    default:
                    begin
                        // Codes above turn off restart the boost phase.
                        phase_next = slseq_pkg::PH_BOOST_ON;
                    end
                endcase
            end
            slseq_pkg::CMD_SET:
            begin
                toggle_next = item.request_value;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= slseq_pkg::PH_IDLE;
            busy_reg      <= 1'b0;
            phase_tmr_reg <= '0;
            blink_tmr_reg <= '0;
            pend_reg      <= '0;
            toggle_reg    <= 1'b0;
            boost_reg     <= 1'b0;
            coil_reg      <= 1'b0;
            led_reg       <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            busy_reg      <= busy_next;
            phase_tmr_reg <= phase_tmr_next;
            blink_tmr_reg <= blink_tmr_next;
            pend_reg      <= pend_next;
            toggle_reg    <= toggle_next;
            boost_reg     <= boost_next;
            coil_reg      <= coil_next;
            led_reg       <= led_next;
        end
    end

    // The word reports the state as it stands after this step.
    always_comb
    begin
        result.boost_enable = boost_next;
        result.coil_enable  = coil_next;
        result.led_on       = led_next;
        result.busy_res     = busy_next;
        result.phase        = phase_next;
    end

endmodule

`default_nettype wire
